/* sv/bsfr_pkg.sv */
// Shared types, event codes, constants and the CRC step for the frame receiver.
`timescale 1ns / 1ps

package bsfr_pkg;

    localparam logic [2:0] FUNC_OWN_ADDR = 3'd0;
    localparam logic [2:0] FUNC_GEN_CALL = 3'd1;
    localparam logic [2:0] FUNC_DATA     = 3'd2;
    localparam logic [2:0] FUNC_STOP     = 3'd3;
    localparam logic [2:0] FUNC_READ     = 3'd4;

    localparam logic [15:0] CRC_SEED   = 16'h1d0f;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  BTN_MARK   = 8'hF5;
    localparam logic [7:0]  START_B4   = 8'h10;
    localparam logic [7:0]  START_B5   = 8'h61;
    localparam logic [7:0]  READ_REPLY = 8'h2F;
    localparam logic [7:0]  SEL_LOW    = 8'h04;
    localparam logic [7:0]  SEL_HIGH   = 8'h07;
    localparam logic [7:0]  SIDE_A     = 8'h03;
    localparam logic [7:0]  SIDE_B     = 8'h04;

    typedef struct packed {
        logic        is_stop;
        logic        len_ok;
        logic        gc;
        logic        ack;
        logic [7:0]  tx;
        logic [15:0] crc2;
        logic [7:0]  b1;
        logic [7:0]  b4;
        logic [7:0]  b5;
        logic [7:0]  b6;
        logic [7:0]  b7;
    } t_stop_req;

    typedef struct packed {
        logic [7:0] buttons;
        logic       startup;
    } t_check_res;

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        r = acc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

/* sv/bsfr_store.sv */
// Frame byte memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module bsfr_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [7:0]    o_rdata_a,
    output logic [7:0]    o_rdata_b
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

/* sv/bsfr_check.sv */
// Stop-time checks: startup frame match and CRC-guarded button update.
`timescale 1ns / 1ps

module bsfr_check
    import bsfr_pkg::*;
(
    input  t_stop_req  i_req,
    input  logic [7:0] i_tail_hi,
    input  logic [7:0] i_tail_lo,
    input  logic [7:0] i_buttons,
    input  logic       i_startup,
    output t_check_res o_res
);

    logic       crc_ok;
    logic       sel_ok;
    logic       side_ok;
    logic [7:0] sel_off;
    logic [7:0] side_off;
    logic [2:0] bit_pos;
    logic [7:0] mask;
    logic [7:0] addend;

    always_comb begin
        crc_ok   = (i_req.b1 == BTN_MARK) && i_req.len_ok
                   && (i_tail_hi == i_req.crc2[15:8]) && (i_tail_lo == i_req.crc2[7:0]);
        sel_ok   = (i_req.b5 >= SEL_LOW) && (i_req.b5 <= SEL_HIGH);
        side_ok  = (i_req.b6 == SIDE_A) || (i_req.b6 == SIDE_B);
        sel_off  = i_req.b5 - SEL_LOW;
        side_off = i_req.b6 - SIDE_A;
        bit_pos  = {sel_off[1:0], side_off[0]};
        mask     = 8'h01 << bit_pos;
        addend   = i_req.b7 << bit_pos;

        o_res.buttons = i_buttons;
        o_res.startup = i_startup;
        if (i_req.is_stop) begin
            if (i_req.gc && (i_req.b4 == START_B4) && (i_req.b5 == START_B5)) begin
                o_res.startup = 1'b1;
            end
            if (crc_ok && sel_ok && side_ok) begin
                o_res.buttons = (i_buttons & ~mask) + addend;
            end
        end
    end

endmodule

/* sv/bus_slave_frame_receiver.sv */
// Top level of the two-wire slave frame receiver.
// Slave channel: one decoded bus event per beat, event code on tuser, bus byte on tdata.
// Master channel: exactly one result beat per event, in order.
// An accepted event is held in the check stage, then in the output register that drives its result beat.
// Throughput: one event per cycle unless the master side stalls; the frame
// memory has one write port and two read ports, so a data byte is stored and a
// stop reads the two trailing CRC bytes in the cycle of acceptance, the stop
// check following in the next cycle. Index, CRC history and bytes 1, 4, 5, 6, 7
// are held in registers beside the memory.
// Reset (synchronous, active low) clears index, CRC history, flags, buttons and
// the fixed-position byte copies; memory contents are only read after being
// written in the current frame, so it needs no clearing.
// When the master side stalls, the output beat holds, the check stage holds, and
// the slave side keeps accepting until both stages are full.
`timescale 1ns / 1ps

module bus_slave_frame_receiver
    import bsfr_pkg::*;
#(
    parameter int FRAME_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] bus_byte
    input  logic [2:0]  i_s_tuser,   // [2:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [0] ack_next, [8:1] tx_byte, [16:9] buttons,
                                     // [17] startup_flag, [23:18] zero
);

    localparam int IW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    logic [IW-1:0] r_wi;
    logic [IW-1:0] n_wi;
    logic [15:0]   r_crc0, r_crc1, r_crc2;
    logic [15:0]   n_crc0, n_crc1, n_crc2;
    logic          r_gc, n_gc;
    logic [7:0]    r_b1, r_b4, r_b5, r_b6, r_b7;
    logic [7:0]    r_buttons;
    logic          r_startup;

    logic          r_s1_valid;
    t_stop_req     r_s1;
    t_stop_req     n_s1;
    logic          r_out_valid;
    logic [23:0]   r_out_data;

    logic          accept;
    logic          s1_move;
    logic          store_we;
    logic [IW-1:0] idx_m1;
    logic [IW-1:0] idx_m2;
    logic [7:0]    tail_hi;
    logic [7:0]    tail_lo;
    t_check_res    chk;

    logic [2:0]    func;
    logic [7:0]    bus_byte;

    assign func     = i_s_tuser;
    assign bus_byte = i_s_tdata;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_move;
    assign accept     = i_s_tvalid && o_s_tready;

    assign idx_m1 = r_wi - IW'(1);
    assign idx_m2 = r_wi - IW'(2);

    always_comb begin
        n_wi     = r_wi;
        n_crc0   = r_crc0;
        n_crc1   = r_crc1;
        n_crc2   = r_crc2;
        n_gc     = r_gc;
        store_we = 1'b0;

        n_s1.is_stop = (func == FUNC_STOP);
        n_s1.len_ok  = (r_wi >= IW'(2));
        n_s1.gc      = r_gc;
        n_s1.ack     = 1'b1;
        n_s1.tx      = 8'h00;
        n_s1.crc2    = r_crc2;
        n_s1.b1      = r_b1;
        n_s1.b4      = r_b4;
        n_s1.b5      = r_b5;
        n_s1.b6      = r_b6;
        n_s1.b7      = r_b7;

        unique case (func)
            FUNC_OWN_ADDR, FUNC_GEN_CALL: begin
                n_wi   = '0;
                n_crc0 = crc_step(CRC_SEED, bus_byte);
                n_crc1 = CRC_SEED;
                n_crc2 = CRC_SEED;
                n_gc   = (func == FUNC_GEN_CALL);
            end
            FUNC_DATA: begin
                n_s1.ack = (r_wi < IW'(FRAME_DEPTH - 2));
                if (r_wi < IW'(FRAME_DEPTH)) begin
                    store_we = 1'b1;
                    n_wi     = r_wi + IW'(1);
                    n_crc2   = r_crc1;
                    n_crc1   = r_crc0;
                    n_crc0   = crc_step(r_crc0, bus_byte);
                end
            end
            FUNC_READ: begin
                n_s1.ack = 1'b0;
                n_s1.tx  = READ_REPLY;
            end
            default: begin
            end
        endcase
    end

    bsfr_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (accept && store_we),
        .i_waddr   (r_wi[AW-1:0]),
        .i_wdata   (bus_byte),
        .i_re      (accept),
        .i_raddr_a (idx_m2[AW-1:0]),
        .i_raddr_b (idx_m1[AW-1:0]),
        .o_rdata_a (tail_hi),
        .o_rdata_b (tail_lo)
    );

    bsfr_check u_check (
        .i_req     (r_s1),
        .i_tail_hi (tail_hi),
        .i_tail_lo (tail_lo),
        .i_buttons (r_buttons),
        .i_startup (r_startup),
        .o_res     (chk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi   <= '0;
            r_crc0 <= CRC_SEED;
            r_crc1 <= CRC_SEED;
            r_crc2 <= CRC_SEED;
            r_gc   <= 1'b0;
            r_b1   <= 8'h00;
            r_b4   <= 8'h00;
            r_b5   <= 8'h00;
            r_b6   <= 8'h00;
            r_b7   <= 8'h00;
        end else if (accept) begin
            r_wi   <= n_wi;
            r_crc0 <= n_crc0;
            r_crc1 <= n_crc1;
            r_crc2 <= n_crc2;
            r_gc   <= n_gc;
            if (store_we) begin
                if (r_wi == IW'(1)) r_b1 <= bus_byte;
                if (r_wi == IW'(4)) r_b4 <= bus_byte;
                if (r_wi == IW'(5)) r_b5 <= bus_byte;
                if (r_wi == IW'(6)) r_b6 <= bus_byte;
                if (r_wi == IW'(7)) r_b7 <= bus_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buttons   <= 8'h00;
            r_startup   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_buttons   <= chk.buttons;
                r_startup   <= chk.startup;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= {6'b0, chk.startup, chk.buttons, r_s1.tx, r_s1.ack};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
